[hw/rtl/ate_pkg.sv]
// Shared types and constants for the ATA task-file address encoder.
`timescale 1ns / 1ps
`default_nettype none
package ate_pkg;

  // Address mode carried with every register write
  typedef enum logic [1:0] {
    MODE_CHS   = 2'd0,
    MODE_LBA28 = 2'd1,
    MODE_LBA48 = 2'd2
  } mode_e;

  // Task-file register identifiers
  localparam logic [3:0] REG_DRIVE_SEL = 4'd0;
  localparam logic [3:0] REG_COUNT_HI  = 4'd1;
  localparam logic [3:0] REG_LBA3      = 4'd2;
  localparam logic [3:0] REG_LBA4      = 4'd3;
  localparam logic [3:0] REG_LBA5      = 4'd4;
  localparam logic [3:0] REG_COUNT_LO  = 4'd5;
  localparam logic [3:0] REG_LBA0      = 4'd6;
  localparam logic [3:0] REG_LBA1      = 4'd7;
  localparam logic [3:0] REG_LBA2      = 4'd8;

  // Configuration register indexes
  localparam logic CFG_LBA_CAPABLE  = 1'b0;
  localparam logic CFG_DEVICE_SLAVE = 1'b1;

  // Address thresholds and drive select bases
  localparam int unsigned Lba48Shift = 28;
  localparam logic [7:0]  SelLba     = 8'hE0;
  localparam logic [7:0]  SelChs     = 8'hA0;

  // floor(n / 63) == (n * ChsRecip) >> ChsRecipShift for every n below 2^28
  localparam logic [28:0] ChsRecip      = 29'd272696337;
  localparam int unsigned ChsRecipShift = 34;

  // One classified request: every byte the back end needs to emit
  typedef struct packed {
    mode_e      mode;
    logic [7:0] sel;
    logic [7:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] hi0;
    logic [7:0] hi1;
    logic [7:0] hi2;
  } desc_t;

  // Queue status towards the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

[hw/rtl/ata_address_taskfile_encoder_top.sv]
// Top level of the ATA task-file address encoder.
// A request passes the front-end register, the queue and the output register.
// Throughput: one register write per cycle from the single output sequencer while
// the receiver is ready; a request is nine writes in LBA48 mode, five in LBA28 or CHS.
// Accepting stops once the queue holds QueueDepth requests and the front end one more.
// Reset clears the pipeline, queue and sequencer and sets both config registers to 0.
`timescale 1ns / 1ps
`default_nettype none
module ata_address_taskfile_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_wdata_i,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // [47:0] block_address, [55:48] sector_count
  // Register write stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] register_value
  output logic [5:0]       m_axis_tuser,   // [3:0] register_id, [5:4] address_mode
  output logic             m_axis_tlast    // last_write
);

  logic            lba_capable_q, device_slave_q;
  logic            push, pop;
  ate_pkg::desc_t  wdesc, rdesc;
  ate_pkg::qstat_t qstat;
  ate_pkg::mode_e  mode;
  logic [3:0]      reg_id;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_capable_q  <= 1'b0;
      device_slave_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ate_pkg::CFG_LBA_CAPABLE:  lba_capable_q  <= cfg_wdata_i;
        ate_pkg::CFG_DEVICE_SLAVE: device_slave_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ate_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lba_capable_i  (lba_capable_q),
    .device_slave_i (device_slave_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .addr_i         (s_axis_tdata[47:0]),
    .count_i        (s_axis_tdata[55:48]),
    .qstat_i        (qstat),
    .push_o         (push),
    .desc_o         (wdesc)
  );

  ate_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdesc),
    .pop_i   (pop),
    .rdata_o (rdesc),
    .stat_o  (qstat)
  );

  ate_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (rdesc),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .reg_id_o    (reg_id),
    .reg_val_o   (m_axis_tdata),
    .mode_o      (mode),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = {mode, reg_id};

  // The final write of every sequence is address byte 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> reg_id == ate_pkg::REG_LBA2)
    else $error("last write is not address byte 2");

  // Short sequences never touch count high or the upper address bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode != ate_pkg::MODE_LBA48 |->
      reg_id == ate_pkg::REG_DRIVE_SEL || reg_id == ate_pkg::REG_COUNT_LO ||
      reg_id == ate_pkg::REG_LBA0 || reg_id == ate_pkg::REG_LBA1 ||
      reg_id == ate_pkg::REG_LBA2)
    else $error("high register written outside LBA48 mode");

  // A transfer of a non-final write is followed by the next write of the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && mode == $past(mode) && reg_id != ate_pkg::REG_DRIVE_SEL)
    else $error("register sequence broken");

  // The queue is only popped while it holds a descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[hw/rtl/ate_front.sv]
// Front end: accepts requests, works out the CHS quotient and builds a descriptor.
`timescale 1ns / 1ps
`default_nettype none
module ate_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          lba_capable_i,
  input  wire logic          device_slave_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [47:0]   addr_i,
  input  wire logic [7:0]    count_i,
  input  wire ate_pkg::qstat_t qstat_i,
  output logic               push_o,
  output ate_pkg::desc_t     desc_o
);

  logic        a_valid_q, a_valid_d;
  logic [47:0] addr_q;
  logic [7:0]  count_q;
  logic [19:0] quot_q;
  logic [56:0] prod;
  logic        accept;

  logic        lba48;
  logic [5:0]  rem;
  logic [7:0]  sect;
  logic [15:0] cyl;
  logic [3:0]  head;
  logic [7:0]  slave_bit;

  assign in_ready_o = !a_valid_q || !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = a_valid_q && !qstat_i.full;

  // Quotient by 63 through the reciprocal, registered before use; the
  // cylinder is cut to 16 bits, so quotient bits above 19 are never needed
  assign prod = {29'd0, addr_i[27:0]} * {28'd0, ate_pkg::ChsRecip};

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (push_o) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= addr_i;
      count_q <= count_i;
      quot_q  <= prod[ate_pkg::ChsRecipShift +: 20];
    end
  end

  // CHS split: remainder is addr - 63q, so only the low six bits matter
  assign rem       = addr_q[5:0] + quot_q[5:0];
  assign sect      = {2'b00, rem} + 8'd1;
  assign cyl       = quot_q[19:4];
  assign head      = quot_q[3:0];
  assign lba48     = |addr_q[47:ate_pkg::Lba48Shift];
  assign slave_bit = {3'b000, device_slave_i, 4'h0};

  // Descriptor build
  always_comb begin
    desc_o.count = count_q;
    desc_o.hi0   = addr_q[31:24];
    desc_o.hi1   = addr_q[39:32];
    desc_o.hi2   = addr_q[47:40];
    desc_o.b0    = addr_q[7:0];
    desc_o.b1    = addr_q[15:8];
    desc_o.b2    = addr_q[23:16];
    priority if (lba48) begin
      desc_o.mode = ate_pkg::MODE_LBA48;
      desc_o.sel  = ate_pkg::SelLba | slave_bit;
    end else if (lba_capable_i) begin
      desc_o.mode = ate_pkg::MODE_LBA28;
      desc_o.sel  = ate_pkg::SelLba | slave_bit | {4'h0, addr_q[27:24]};
    end else begin
      desc_o.mode = ate_pkg::MODE_CHS;
      desc_o.sel  = ate_pkg::SelChs | slave_bit | {4'h0, head};
      desc_o.b0   = sect;
      desc_o.b1   = cyl[7:0];
      desc_o.b2   = cyl[15:8];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ate_queue.sv]
// Small register queue of descriptors between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ate_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ate_pkg::desc_t  wdata_i,
  input  wire logic            pop_i,
  output ate_pkg::desc_t       rdata_o,
  output ate_pkg::qstat_t      stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  ate_pkg::desc_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == DepthCnt);
  assign stat_o.empty = (cnt_q == '0);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ate_back.sv]
// Back end: walks the register write sequence of the head descriptor.
`timescale 1ns / 1ps
`default_nettype none
module ate_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ate_pkg::desc_t  desc_i,
  input  wire ate_pkg::qstat_t qstat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [3:0]           reg_id_o,
  output logic [7:0]           reg_val_o,
  output ate_pkg::mode_e       mode_o,
  output logic                 last_o
);

  logic [3:0]     step_q, step_d;
  logic           out_valid_q;
  logic [3:0]     reg_id_q;
  logic [7:0]     reg_val_q;
  ate_pkg::mode_e mode_q;
  logic           last_q;
  logic           advance, issue, is_last;
  logic [7:0]     val;

  assign advance = !out_valid_q || out_ready_i;
  assign issue   = advance && !qstat_i.empty;
  assign is_last = (step_q == ate_pkg::REG_LBA2);
  assign pop_o   = issue && is_last;

  // Byte for the current register
  always_comb begin
    unique case (step_q)
      ate_pkg::REG_DRIVE_SEL: val = desc_i.sel;
      ate_pkg::REG_COUNT_HI:  val = 8'h00;
      ate_pkg::REG_LBA3:      val = desc_i.hi0;
      ate_pkg::REG_LBA4:      val = desc_i.hi1;
      ate_pkg::REG_LBA5:      val = desc_i.hi2;
      ate_pkg::REG_COUNT_LO:  val = desc_i.count;
      ate_pkg::REG_LBA0:      val = desc_i.b0;
      ate_pkg::REG_LBA1:      val = desc_i.b1;
      ate_pkg::REG_LBA2:      val = desc_i.b2;
      default:                val = 8'h00;
    endcase
  end

  // Next register: short sequences skip count high and the high address bytes
  always_comb begin
    step_d = step_q;
    if (issue) begin
      priority if (is_last) begin
        step_d = ate_pkg::REG_DRIVE_SEL;
      end else if (step_q == ate_pkg::REG_DRIVE_SEL && desc_i.mode != ate_pkg::MODE_LBA48) begin
        step_d = ate_pkg::REG_COUNT_LO;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ate_pkg::REG_DRIVE_SEL;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (advance) begin
        out_valid_q <= !qstat_i.empty;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      reg_id_q  <= step_q;
      reg_val_q <= val;
      mode_q    <= desc_i.mode;
      last_q    <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_id_o    = reg_id_q;
  assign reg_val_o   = reg_val_q;
  assign mode_o      = mode_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

[sim/tb_ata_address_taskfile_encoder_top.sv]
// Self-checking testbench for the ATA task-file address encoder top level.
`timescale 1ns / 1ps
module tb_ata_address_taskfile_encoder_top;

  localparam int unsigned ChsSectors    = 63;
  localparam int unsigned ChsTrack      = 16 * 63;
  localparam logic [47:0] Lba48Start    = 48'h1000_0000;
  localparam logic [47:0] ChsCylWrap    = 48'd66060288;   // 65536 cylinders of 1008 sectors
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 125;

  // One expected task-file register write
  typedef struct {
    logic [3:0]      id;
    logic [7:0]      value;
    ate_pkg::mode_e  mode;
    logic            last;
  } reg_write_t;

  // Works out the register writes a request causes and checks them in order
  class taskfile_scoreboard;
    logic       lba_capable;
    logic       device_slave;
    int         mismatches;
    reg_write_t queued_reg_writes[$];

    function new();
      lba_capable  = 1'b0;
      device_slave = 1'b0;
      mismatches   = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void queue_write(logic [3:0] id, logic [7:0] value, ate_pkg::mode_e mode,
                              logic last);
      reg_write_t w;
      w.id    = id;
      w.value = value;
      w.mode  = mode;
      w.last  = last;
      queued_reg_writes.push_back(w);
    endfunction

    // Accepted request: classify the address and queue its write sequence
    function void note_request(logic [47:0] addr, logic [7:0] cnt);
      ate_pkg::mode_e    mode;
      logic [7:0]        sel, b0, b1, b2, slave_sel;
      longint unsigned   a, rem, t, cyl, head;
      a         = addr;
      slave_sel = {3'b000, device_slave, 4'b0000};
      if (addr >= Lba48Start) begin
        mode = ate_pkg::MODE_LBA48;
        sel  = ate_pkg::SelLba | slave_sel;
        b0   = addr[7:0];
        b1   = addr[15:8];
        b2   = addr[23:16];
      end else if (lba_capable) begin
        mode = ate_pkg::MODE_LBA28;
        sel  = ate_pkg::SelLba | slave_sel | {4'b0000, addr[27:24]};
        b0   = addr[7:0];
        b1   = addr[15:8];
        b2   = addr[23:16];
      end else begin
        // CHS: 16 heads, 63 sectors per track, cylinder cut to 16 bits
        mode = ate_pkg::MODE_CHS;
        rem  = a % ChsSectors;
        t    = a - rem;
        cyl  = (t / ChsTrack) & 64'hFFFF;
        head = (t % ChsTrack) / ChsSectors;
        sel  = ate_pkg::SelChs | slave_sel | {4'b0000, head[3:0]};
        b0   = 8'(rem + 1);
        b1   = cyl[7:0];
        b2   = cyl[15:8];
      end
      queue_write(ate_pkg::REG_DRIVE_SEL, sel, mode, 1'b0);
      if (mode == ate_pkg::MODE_LBA48) begin
        queue_write(ate_pkg::REG_COUNT_HI, 8'h00, mode, 1'b0);
        queue_write(ate_pkg::REG_LBA3, addr[31:24], mode, 1'b0);
        queue_write(ate_pkg::REG_LBA4, addr[39:32], mode, 1'b0);
        queue_write(ate_pkg::REG_LBA5, addr[47:40], mode, 1'b0);
      end
      queue_write(ate_pkg::REG_COUNT_LO, cnt, mode, 1'b0);
      queue_write(ate_pkg::REG_LBA0, b0, mode, 1'b0);
      queue_write(ate_pkg::REG_LBA1, b1, mode, 1'b0);
      queue_write(ate_pkg::REG_LBA2, b2, mode, 1'b1);
    endfunction

    // Accepted register write: compare with the oldest expectation
    task check_write(input logic [3:0] id, input logic [7:0] value,
                     input logic [1:0] mode, input logic last);
      reg_write_t w;
      if (queued_reg_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write id=%0d value=%02h mode=%0d last=%0b",
                                  id, value, mode, last));
      end else begin
        w = queued_reg_writes.pop_front();
        if (id !== w.id || value !== w.value || mode !== w.mode || last !== w.last)
          report_mismatch($sformatf(
            "got id=%0d value=%02h mode=%0d last=%0b, want id=%0d value=%02h mode=%0d last=%0b",
            id, value, mode, last, w.id, w.value, w.mode, w.last));
      end
    endtask
  endclass

  // DUT signals; the inputs are driven from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;     // [47:0] block_address, [55:48] sector_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] register_value
  logic [5:0]  m_axis_tuser;           // [3:0] register_id, [5:4] address_mode
  logic        m_axis_tlast;

  // Stimulus controls
  logic        sender_idles = 1'b1;
  logic        sink_idles   = 1'b1;
  logic        hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  taskfile_scoreboard sb;

  ata_address_taskfile_encoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure while sink_idles is set, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (sink_idles) begin
      m_axis_tready = ($urandom_range(99) >= 10);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Monitor both streams at the rising edge; watchdog on quiet cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[47:0], s_axis_tdata[55:48]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_write(m_axis_tuser[3:0], m_axis_tdata, m_axis_tuser[5:4], m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Offer one request and hold it until the transfer; entered and left at a falling edge
  task automatic send_request(input logic [47:0] addr, input logic [7:0] cnt);
    while (sender_idles && $urandom_range(99) < 10) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {cnt, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every queued write has come out
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.queued_reg_writes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    if (idx == ate_pkg::CFG_LBA_CAPABLE) sb.lba_capable = value;
    else sb.device_slave = value;
  endtask

  task automatic apply_settings(input logic lba, input logic slave);
    wait_drained();
    write_config(ate_pkg::CFG_LBA_CAPABLE, lba);
    write_config(ate_pkg::CFG_DEVICE_SLAVE, slave);
  endtask

  // Address mix: full range, below the LBA48 start, low addresses, both boundaries, extremes
  function automatic logic [47:0] rand_address();
    logic [63:0] w;
    logic [47:0] a;
    w = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0, 1, 2: a = w[47:0];
      3, 4, 5: a = {20'd0, w[27:0]};
      6:       a = Lba48Start + 48'($urandom_range(31)) - 48'd16;
      7:       a = 48'($urandom_range(4095));
      8:       a = ChsCylWrap + 48'($urandom_range(127)) - 48'd64;
      default: a = $urandom_range(1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
    endcase
    return a;
  endfunction

  task automatic run_random_phase(input int unsigned n, input bit with_hold);
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == 30) hold_req = 1'b1;
      send_request(rand_address(), 8'($urandom_range(255)));
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: CHS boundaries, the cylinder cut and the LBA48 start, no slave
    apply_settings(1'b0, 1'b0);
    send_request(48'd0, 8'd0);
    send_request(48'd62, 8'd255);
    send_request(48'd63, 8'd1);
    send_request(48'd1007, 8'd2);
    send_request(48'd1008, 8'd3);
    send_request(ChsCylWrap - 48'd1, 8'h80);
    send_request(ChsCylWrap, 8'h7F);
    send_request(Lba48Start - 48'd1, 8'hAA);
    send_request(Lba48Start, 8'h55);
    send_request(48'hFFFF_FFFF_FFFF, 8'd255);

    // Directed: LBA28 with the high nibble in drive select and LBA48 addresses, slave drive
    apply_settings(1'b1, 1'b1);
    send_request(48'd0, 8'd0);
    send_request(48'h0ABC_DEF1, 8'h5A);
    send_request(Lba48Start - 48'd1, 8'd255);
    send_request(48'h0F00_0000, 8'hA5);
    send_request(Lba48Start, 8'd1);
    send_request(48'hFFFF_FFFF_FFFF, 8'd0);
    send_request(48'hA5A5_5A5A_A5A5, 8'h3C);

    // Directed: CHS and one LBA48 address with slave drive
    apply_settings(1'b0, 1'b1);
    send_request(48'd1007, 8'd255);
    send_request(Lba48Start - 48'd1, 8'd0);
    send_request(48'h5A5A_A5A5_5A5A, 8'hC3);

    // Random phases over every setting; one with a long receiver hold-off
    apply_settings(1'b1, 1'b0);
    run_random_phase(PhaseItems, 1'b1);

    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    apply_settings(1'b0, 1'b1);
    run_random_phase(PhaseItems, 1'b0);

    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    apply_settings(1'b1, 1'b1);
    run_random_phase(PhaseItems, 1'b0);

    apply_settings(1'b0, 1'b0);
    run_random_phase(PhaseItems, 1'b0);

    wait_drained();
    if (sb.mismatches == 0 && sb.queued_reg_writes.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ate_pkg.sv
hw/rtl/ate_front.sv
hw/rtl/ate_queue.sv
hw/rtl/ate_back.sv
hw/rtl/ata_address_taskfile_encoder_top.sv
sim/tb_ata_address_taskfile_encoder_top.sv
